>>> rtl/gpbc_pkg.sv
package gpbc_pkg;

  // field and register widths
  localparam int unsigned WS_W       = 6;
  localparam int unsigned LIM_W      = 20;
  localparam int unsigned FLASH_W    = 20;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned DT_W       = 20;
  localparam int unsigned TOT_W      = 22;
  localparam int unsigned LED_W      = 24;
  localparam int unsigned WIDTH_W    = 20;
  localparam int unsigned IN_W       = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // result word without the slot field
  localparam int unsigned RES_FIXED_W = 1 + TOT_W + 2 * CNT_W + DT_W;

  localparam int unsigned DEF_SLOTS = 60;

  // saturation limits
  localparam logic [CNT_W-1:0]   CNT_MAX      = '1;
  localparam logic [DT_W-1:0]    DEAD_SUM_MAX = 20'd1000000;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX    = '1;
  localparam logic [LED_W-1:0]   LED_MAX      = '1;

  // register reset values
  localparam logic [WS_W-1:0]    WS_RST    = 6'd60;
  localparam logic [LIM_W-1:0]   LIM_RST   = 20'd800;
  localparam logic [FLASH_W-1:0] FLASH_RST = 20'd5000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH  = 2'd2;

  // input word bit positions
  localparam int unsigned IN_EDGE = 0;
  localparam int unsigned IN_NSEC = 1;
  localparam int unsigned IN_CLR  = 2;

  typedef enum logic {
    MODE_RUN,
    MODE_SWEEP
  } mode_e;

endpackage

>>> rtl/geiger_pulse_binning_counter_core.sv
// channel   | direction | handshake                    | word
// s_axis    | in        | s_axis_tvalid / s_axis_tready | edge_seen, new_second, clear_all
// m_axis    | out       | m_axis_tvalid / m_axis_tready | led_on, window_total, slot_number,
//           |           |                              | second_counts, second_dead_pulses,
//           |           |                              | second_dead_time
// cfg       | in        | cfg_valid_i / cfg_ready_o    | register index, write data
//
// one tick word per cycle sustained while results are taken and no rebuild runs; a word passes
// through the input register, then a single-pass update into the result register
// the count ring is a one-write, one-read memory; the sample that leaves the window is
// prefetched through a registered read so a boundary on every tick still runs at full rate
// a write of window_seconds starts a rebuild of the window sum from the ring, with both
// ready outputs low while the rebuild runs
// reset puts all control state in its reset value and clears the ring valid bits at once, no clearing pass
// a stalled result holds while the input register still takes one more word
module geiger_pulse_binning_counter_core #(
  parameter int unsigned SLOTS = gpbc_pkg::DEF_SLOTS,
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned RES_W = gpbc_pkg::RES_FIXED_W + SLOT_W,
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick word: edge_seen, new_second, clear_all, zero fill
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gpbc_pkg::IN_W-1:0]         s_axis_tdata,
  // result word: led_on, window_total, slot_number, second_counts,
  // second_dead_pulses, second_dead_time, zero fill
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_W-1:0]                  m_axis_tdata,
  // register write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gpbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gpbc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gpbc_pkg::*;

  // window length and address arithmetic widths
  localparam int unsigned NW = (SLOT_W + 1 > WS_W + 1) ? SLOT_W + 1 : WS_W + 1;
  localparam int unsigned AW = NW + 1;

  // configuration registers
  logic [WS_W-1:0]    ws_q;
  logic [LIM_W-1:0]   lim_q;
  logic [FLASH_W-1:0] flash_q;

  // per-tick state
  logic [SLOT_W-1:0]  slot_q;
  logic               await_q;
  logic [WIDTH_W-1:0] width_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   dpul_q;
  logic [DT_W-1:0]    dtime_q;
  logic [TOT_W-1:0]   prev_q, prev_d;   // sum of the older slots inside the window
  logic [LED_W-1:0]   led_q, led_d;
  logic [SLOTS-1:0]   bin_vld_q, bin_vld_d;

  // rebuild sequencer
  mode_e              mode_q, mode_d;
  logic [SLOT_W-1:0]  sweep_cnt_q, sweep_cnt_d;
  logic               acc_vld_q, acc_vld_d;

  // pipeline registers
  logic               in_vld_q;
  logic [2:0]         in_item_q;
  logic               out_vld_q;
  logic [OUT_W-1:0]   out_data_q;

  // count ring
  logic [CNT_W-1:0]   bin_mem [SLOTS];
  logic [CNT_W-1:0]   rd_q;
  logic               rvld_q;
  logic               fwd_q;
  logic [CNT_W-1:0]   fwd_data_q;
  logic [CNT_W-1:0]   drop_view;

  logic               proc_fire;
  logic               cfg_fire;
  logic               edge_in, nsec_in, clr_in;
  logic [NW-1:0]      win_n;
  logic [NW-1:0]      new_n;

  // update path
  logic [SLOT_W-1:0]  slot_a, slot_b;
  logic               await_a, await_c;
  logic [WIDTH_W-1:0] width_a, width_b, width_c;
  logic [CNT_W-1:0]   cnt_a, cnt_b, cnt_c;
  logic [CNT_W-1:0]   dpul_a, dpul_b, dpul_c;
  logic [DT_W-1:0]    dtime_a, dtime_b, dtime_c;
  logic [TOT_W-1:0]   prev_a, prev_b;
  logic [LED_W-1:0]   led_b, led_c;
  logic [SLOTS-1:0]   vld_a;
  logic [CNT_W-1:0]   drop_eff;
  logic [DT_W:0]      dt_sum;
  logic [LED_W:0]     led_sum;
  logic               led_on;
  logic [TOT_W-1:0]   total;

  // memory ports
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  logic [CNT_W-1:0]   wdata;
  logic [SLOT_W-1:0]  slot_n;
  logic [AW-1:0]      run_sum, sweep_sum;
  logic [SLOT_W-1:0]  run_addr, sweep_addr, raddr;

  function automatic logic [NW-1:0] win_len(input logic [WS_W-1:0] ws);
    logic [NW-1:0] w;
    w = NW'(ws);
    return (w > NW'(SLOTS)) ? NW'(SLOTS) : w;
  endfunction

  assign edge_in = in_item_q[IN_EDGE];
  assign nsec_in = in_item_q[IN_NSEC];
  assign clr_in  = in_item_q[IN_CLR];

  assign win_n = win_len(ws_q);
  assign new_n = win_len(cfg_data_i[WS_W-1:0]);

  // handshakes: result register parts the two sides
  assign proc_fire     = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = (mode_q == MODE_RUN) & (~in_vld_q | proc_fire);
  assign cfg_ready_o   = (mode_q == MODE_RUN);
  assign cfg_fire      = cfg_valid_i & cfg_ready_o;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // the slot that leaves the window on the next boundary, with write forwarding
  assign drop_view = fwd_q ? fwd_data_q : (rvld_q ? rd_q : '0);

  // single-pass tick update: clear, boundary, width measure, edge
  always_comb begin
    slot_a  = slot_q;
    await_a = await_q;
    width_a = width_q;
    cnt_a   = cnt_q;
    dpul_a  = dpul_q;
    dtime_a = dtime_q;
    prev_a  = prev_q;
    vld_a   = bin_vld_q;
    drop_eff = drop_view;
    if (clr_in) begin
      slot_a   = '0;
      await_a  = 1'b0;
      width_a  = '0;
      cnt_a    = '0;
      dpul_a   = '0;
      dtime_a  = '0;
      prev_a   = '0;
      vld_a    = '0;
      drop_eff = '0;
    end

    slot_b  = slot_a;
    cnt_b   = cnt_a;
    dpul_b  = dpul_a;
    dtime_b = dtime_a;
    prev_b  = prev_a;
    led_b   = led_q;
    if (nsec_in) begin
      slot_b  = (slot_a == SLOT_W'(SLOTS - 1)) ? '0 : slot_a + 1'b1;
      cnt_b   = '0;
      dpul_b  = '0;
      dtime_b = '0;
      if (led_q != '0) begin
        led_b = LED_W'(flash_q);
      end
      // finished second enters, oldest one leaves
      if (win_n >= NW'(2)) begin
        prev_b = prev_a + TOT_W'(cnt_a) - TOT_W'(drop_eff);
      end
    end

    width_b = width_a;
    if (await_a && (width_a != WIDTH_MAX)) begin
      width_b = width_a + 1'b1;
    end

    await_c = await_a;
    width_c = width_b;
    cnt_c   = cnt_b;
    dpul_c  = dpul_b;
    dtime_c = dtime_b;
    led_c   = led_b;
    dt_sum  = {1'b0, dtime_b} + {1'b0, width_b};
    led_sum = {1'b0, led_b} + (LED_W + 1)'(flash_q);
    if (edge_in) begin
      if (!await_a) begin
        // pulse start
        cnt_c   = (cnt_b != CNT_MAX) ? cnt_b + 1'b1 : cnt_b;
        led_c   = led_sum[LED_W] ? LED_MAX : led_sum[LED_W-1:0];
        width_c = '0;
        await_c = 1'b1;
      end else if (width_b <= lim_q) begin
        // pulse end inside the dead limit
        dpul_c  = (dpul_b != CNT_MAX) ? dpul_b + 1'b1 : dpul_b;
        dtime_c = (dt_sum > (DT_W + 1)'(DEAD_SUM_MAX)) ? DEAD_SUM_MAX : dt_sum[DT_W-1:0];
        await_c = 1'b0;
        width_c = '0;
      end else begin
        // too wide: restart the measure, still waiting for an end
        width_c = '0;
      end
    end

    led_on = (led_c != '0);
    total  = (win_n == '0) ? '0 : prev_b + TOT_W'(cnt_c);
  end

  // ring write on every boundary, valid bits follow
  assign we    = proc_fire & nsec_in;
  assign waddr = slot_a;
  assign wdata = cnt_a;

  always_comb begin
    bin_vld_d = bin_vld_q;
    if (proc_fire) begin
      bin_vld_d = vld_a;
      if (we) begin
        bin_vld_d[waddr] = 1'b1;
      end
    end
  end

  // prefetch address: oldest slot inside the window after this cycle
  assign slot_n  = proc_fire ? slot_b : slot_q;
  assign run_sum = AW'(slot_n) + AW'(SLOTS) + AW'(1) - AW'(win_n);
  always_comb begin
    if (win_n < NW'(2)) begin
      run_addr = slot_n;
    end else if (run_sum >= AW'(SLOTS)) begin
      run_addr = SLOT_W'(run_sum - AW'(SLOTS));
    end else begin
      run_addr = SLOT_W'(run_sum);
    end
  end

  // rebuild reads the slots behind the current one, oldest first
  assign sweep_sum  = AW'(slot_q) + AW'(SLOTS) - AW'(sweep_cnt_q);
  assign sweep_addr = (sweep_sum >= AW'(SLOTS)) ? SLOT_W'(sweep_sum - AW'(SLOTS))
                                                : SLOT_W'(sweep_sum);
  assign raddr = ((mode_q == MODE_SWEEP) && (sweep_cnt_q != '0)) ? sweep_addr : run_addr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      bin_mem[waddr] <= wdata;
    end
    rd_q       <= bin_mem[raddr];
    fwd_data_q <= wdata;
  end

  // rebuild sequencer and window-sum register
  always_comb begin
    mode_d      = mode_q;
    sweep_cnt_d = sweep_cnt_q;
    acc_vld_d   = 1'b0;
    prev_d      = prev_q;
    case (mode_q)
      MODE_RUN: begin
        if (proc_fire) begin
          prev_d = prev_b;
        end
        if (cfg_fire && (cfg_index_i == CFG_WINDOW)) begin
          mode_d      = MODE_SWEEP;
          sweep_cnt_d = (new_n == '0) ? '0 : SLOT_W'(new_n - 1'b1);
          prev_d      = '0;
        end
      end
      MODE_SWEEP: begin
        if (acc_vld_q) begin
          prev_d = prev_q + TOT_W'(drop_view);
        end
        if (sweep_cnt_q != '0) begin
          sweep_cnt_d = sweep_cnt_q - 1'b1;
          acc_vld_d   = 1'b1;
        end else if (!acc_vld_q) begin
          mode_d = MODE_RUN;
        end
      end
      default: begin
        mode_d = MODE_RUN;
      end
    endcase
  end

  // led countdown on each processed tick word
  assign led_d = proc_fire ? (led_c - LED_W'(led_on)) : led_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= WS_RST;
      lim_q       <= LIM_RST;
      flash_q     <= FLASH_RST;
      slot_q      <= '0;
      await_q     <= 1'b0;
      width_q     <= '0;
      cnt_q       <= '0;
      dpul_q      <= '0;
      dtime_q     <= '0;
      prev_q      <= '0;
      led_q       <= '0;
      bin_vld_q   <= '0;
      mode_q      <= MODE_RUN;
      sweep_cnt_q <= '0;
      acc_vld_q   <= 1'b0;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      rvld_q      <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_WINDOW: ws_q    <= cfg_data_i[WS_W-1:0];
          CFG_DEAD:   lim_q   <= cfg_data_i[LIM_W-1:0];
          CFG_FLASH:  flash_q <= cfg_data_i[FLASH_W-1:0];
          default: ;
        endcase
      end
      if (proc_fire) begin
        slot_q  <= slot_b;
        await_q <= await_c;
        width_q <= width_c;
        cnt_q   <= cnt_c;
        dpul_q  <= dpul_c;
        dtime_q <= dtime_c;
      end
      prev_q      <= prev_d;
      led_q       <= led_d;
      bin_vld_q   <= bin_vld_d;
      mode_q      <= mode_d;
      sweep_cnt_q <= sweep_cnt_d;
      acc_vld_q   <= acc_vld_d;
      rvld_q      <= bin_vld_d[raddr];
      fwd_q       <= we & (raddr == waddr);
      if (s_axis_tvalid && s_axis_tready) begin
        in_vld_q <= 1'b1;
      end else if (proc_fire) begin
        in_vld_q <= 1'b0;
      end
      if (proc_fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= s_axis_tdata[2:0];
    end
    if (proc_fire) begin
      out_data_q <= OUT_W'({dtime_c, dpul_c, cnt_c, slot_b, total, led_on});
    end
  end

endmodule

>>> rtl/gpbc_checker.sv
module gpbc_checker #(
  parameter int unsigned SLOTS = gpbc_pkg::DEF_SLOTS,
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int unsigned RES_W = gpbc_pkg::RES_FIXED_W + SLOT_W,
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [gpbc_pkg::IN_W-1:0]         s_axis_tdata,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [OUT_W-1:0]                  m_axis_tdata,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [gpbc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input logic [gpbc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gpbc_pkg::*;

  localparam int unsigned SLOT_LO = 1 + TOT_W;
  localparam int unsigned DT_LO   = SLOT_LO + SLOT_W + 2 * CNT_W;

  logic [SLOT_W-1:0] res_slot;
  logic [DT_W-1:0]   res_dtime;
  logic              unused_ok;

  assign res_slot  = m_axis_tdata[SLOT_LO +: SLOT_W];
  assign res_dtime = m_axis_tdata[DT_LO +: DT_W];
  assign unused_ok = s_axis_tvalid ^ (|s_axis_tdata) ^ cfg_valid_i ^ (|cfg_index_i)
                   ^ (|cfg_data_i);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed under stall");

  // reported slot stays inside the ring
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, res_slot} < (SLOT_W + 1)'(SLOTS)))
    else $error("slot number outside ring");

  // dead-time sum saturates at its cap
  a_dtime_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_dtime <= DEAD_SUM_MAX))
    else $error("dead-time sum above cap");

  // while the window sum is rebuilt no tick word is taken
  a_rebuild_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_o |-> !s_axis_tready)
    else $error("tick accepted during window rebuild");

endmodule

bind geiger_pulse_binning_counter_core gpbc_checker #(.SLOTS(SLOTS)) u_gpbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);
